FILE: hw/rtl/particle_color_fade_unit_top_macros.svh
// Assertion macros shared by the particle color and fade unit.
`ifndef PARTICLE_COLOR_FADE_UNIT_TOP_MACROS_SVH
`define PARTICLE_COLOR_FADE_UNIT_TOP_MACROS_SVH
`ifndef SYNTH
// The property must hold at every rising clock edge outside reset.
`define PCFU_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("pcfu assertion failed");
// The condition must never be true outside reset.
`define PCFU_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("pcfu forbidden condition seen");
`else
`define PCFU_ASSERT(lbl, clk_s, rstn_s, prop)
`define PCFU_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

FILE: hw/rtl/pcfu_pkg.sv
package pcfu_pkg;

	// Number of restoring division steps, one per cell.
	localparam int DIV_STEPS = 16;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// Configuration register indexes.
	localparam logic [2:0] REG_COLOR_LOW   = 3'd0;
	localparam logic [2:0] REG_COLOR_HIGH  = 3'd1;
	localparam logic [2:0] REG_FUNC_ASSIGN = 3'd2;
	localparam logic [2:0] REG_PER_PART    = 3'd3;
	localparam logic [2:0] REG_RATE        = 3'd4;
	localparam logic [2:0] REG_EDGE_FADE   = 3'd5;

	// How the fade value of an item is formed at the end of the chain.
	typedef enum logic [1:0] {
		FADE_ZERO = 2'd0,
		FADE_ONE  = 2'd1,
		FADE_DIV  = 2'd2
	} fade_sel_t;

	typedef struct packed {
		logic [47:0]        color_low;
		logic [47:0]        color_high;
		logic               function_assigned;
		logic               per_particle_mode;
		logic signed [23:0] rate_of_change;
		logic [16:0]        edge_fade_fraction;
	} cfg_t;

	// Item as it travels along the divider chain.
	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        written;
		fade_sel_t   fsel;
		logic [48:0] rem;
		logic [48:0] den;
		logic [15:0] quo;
	} cell_data_t;

endpackage

FILE: hw/rtl/pcfu_front.sv
module pcfu_front (
	input  logic                clk,
	input  logic                arst_n,
	input  pcfu_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [16:0]         color_func_value,
	input  logic                function_valid,
	input  logic [31:0]         particle_time,
	input  logic [31:0]         lifetime,
	output logic                out_valid,
	output pcfu_pkg::cell_data_t out_data,
	input  logic                out_ready
);

	localparam logic signed [40:0] FAC_LIM = 41'sh2_0000_0000;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [16:0] fv_s1;
	logic        fvalid_s1;
	logic [31:0] t_s1, total_s1;

	logic signed [56:0] rprod_s2;
	logic [48:0]        eh_s2;
	logic [16:0]        fac_s2;
	logic [31:0]        t_s2, total_s2;

	logic signed [34:0]  factor_s3;
	logic                written_s3;
	pcfu_pkg::fade_sel_t fsel_s3;
	logic [48:0]         rem_s3, den_s3;

	logic signed [51:0]  prod_s4 [3];
	logic [15:0]         lo_s4 [3];
	logic                written_s4;
	pcfu_pkg::fade_sel_t fsel_s4;
	logic [48:0]         rem_s4, den_s4;

	logic signed [56:0] rprod_c;
	logic [48:0]        eh_c;
	logic signed [40:0] f_full;
	logic signed [34:0] factor_c;
	logic [48:0]        tn, tot, num;
	logic [49:0]        tsum;
	pcfu_pkg::fade_sel_t fsel_c;
	logic [48:0]        rem_c;
	logic [15:0]        ch_c [3];

	// Stage readiness: a stage loads when empty or when its successor moves.
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1 captures the accepted transaction.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			fv_s1     <= color_func_value;
			fvalid_s1 <= function_valid;
			t_s1      <= particle_time;
			total_s1  <= lifetime;
		end
	end

	// Stage 2: rate times time and the fade ramp length.
	assign rprod_c = $signed(cfg.rate_of_change) * $signed({1'b0, t_s1});
	assign eh_c    = 49'(cfg.edge_fade_fraction) * 49'(total_s1);

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			rprod_s2 <= rprod_c;
			eh_s2    <= eh_c;
			fac_s2   <= fvalid_s1 ? fv_s1 : 17'd0;
			t_s2     <= t_s1;
			total_s2 <= total_s1;
		end
	end

	// Stage 3: select and clamp the interpolation factor and classify the fade.
	assign f_full = rprod_s2[56:16];

	always_comb begin
		if (cfg.per_particle_mode) begin
			if (f_full > FAC_LIM) begin
				factor_c = FAC_LIM[34:0];
			end else if (f_full < -FAC_LIM) begin
				factor_c = 35'(-FAC_LIM);
			end else begin
				factor_c = f_full[34:0];
			end
		end else begin
			factor_c = $signed({18'd0, fac_s2});
		end
	end

	assign tn   = {t_s2, 17'd0};
	assign tot  = {total_s2, 17'd0};
	assign tsum = {1'b0, tn} + {1'b0, eh_s2};
	assign num  = {total_s2 - t_s2, 17'd0};

	always_comb begin
		fsel_c = pcfu_pkg::FADE_ZERO;
		rem_c  = tn;
		if (total_s2 == 32'd0) begin
			fsel_c = pcfu_pkg::FADE_ZERO;
		end else if (tn < eh_s2) begin
			fsel_c = pcfu_pkg::FADE_DIV;
		end else if (tsum <= {1'b0, tot}) begin
			fsel_c = pcfu_pkg::FADE_ONE;
		end else if (cfg.edge_fade_fraction == 17'd0 || t_s2 >= total_s2) begin
			fsel_c = pcfu_pkg::FADE_ZERO;
		end else if (num >= eh_s2) begin
			fsel_c = pcfu_pkg::FADE_ONE;
		end else begin
			fsel_c = pcfu_pkg::FADE_DIV;
			rem_c  = num;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			factor_s3  <= factor_c;
			written_s3 <= cfg.function_assigned || cfg.per_particle_mode;
			fsel_s3    <= fsel_c;
			rem_s3     <= rem_c;
			den_s3     <= eh_s2;
		end
	end

	// Stage 4: one multiplier per color channel, red in the high bits.
	for (genvar c = 0; c < 3; c++) begin : g_chan
		localparam int SH = 32 - 16 * c;
		logic [15:0]        lo, hi;
		logic signed [16:0] diff;
		logic signed [52:0] acc;
		logic signed [36:0] shifted;
		logic signed [37:0] val;

		assign lo   = cfg.color_low[SH +: 16];
		assign hi   = cfg.color_high[SH +: 16];
		assign diff = $signed({1'b0, hi}) - $signed({1'b0, lo});

		always_ff @(posedge clk) begin
			if (rdy4 && v_s3) begin
				prod_s4[c] <= diff * factor_s3;
				lo_s4[c]   <= lo;
			end
		end

		// Round half up, add the low bound and saturate.
		assign acc     = 53'(prod_s4[c]) + 53'sd32768;
		assign shifted = acc[52:16];
		assign val     = 38'(shifted) + $signed({22'd0, lo_s4[c]});

		always_comb begin
			if (!written_s4 || val < 38'sd0) begin
				ch_c[c] = 16'd0;
			end else if (val > 38'sd65535) begin
				ch_c[c] = 16'hFFFF;
			end else begin
				ch_c[c] = val[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			written_s4 <= written_s3;
			fsel_s4    <= fsel_s3;
			rem_s4     <= rem_s3;
			den_s4     <= den_s3;
		end
	end

	always_comb begin
		out_data.red     = ch_c[0];
		out_data.green   = ch_c[1];
		out_data.blue    = ch_c[2];
		out_data.written = written_s4;
		out_data.fsel    = fsel_s4;
		out_data.rem     = rem_s4;
		out_data.den     = den_s4;
		out_data.quo     = 16'd0;
	end

endmodule

FILE: hw/rtl/pcfu_div_cell.sv
module pcfu_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  pcfu_pkg::cell_data_t in_data,
	output logic                 in_ready,
	output logic                 out_valid,
	output pcfu_pkg::cell_data_t out_data,
	input  logic                 out_ready
);

	logic                 valid_q;
	pcfu_pkg::cell_data_t data_q;
	pcfu_pkg::cell_data_t nxt;
	logic [49:0]          r2;
	logic [49:0]          diff;
	logic                 ge;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// One restoring division step: shift the remainder and try the divisor.
	assign r2   = {in_data.rem, 1'b0};
	assign diff = r2 - {1'b0, in_data.den};
	assign ge   = r2 >= {1'b0, in_data.den};

	always_comb begin
		nxt     = in_data;
		nxt.rem = ge ? diff[48:0] : r2[48:0];
		nxt.quo = {in_data.quo[14:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

endmodule

FILE: hw/rtl/particle_color_fade_unit_top.sv
// Particle color and fade unit. Each transaction carries one particle and
// yields one result: the color interpolated between the two bound colors and
// saturated per channel, and a trapezoid fade envelope over the lifetime.
// The unit takes one particle every cycle while it is not stalled and is built of
// four front stages (input capture, the rate and ramp length products, factor
// clamp and fade classification, the channel multipliers) followed by a chain
// of 16 divider cells, each producing one quotient bit of the fade ramp. The
// input stalls only when every stage holds a result and the output is stalled.
// Configuration writes are always ready and must be issued while the unit
// is idle.
`include "particle_color_fade_unit_top_macros.svh"

module particle_color_fade_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [16:0] color_func_value,
	input  logic        function_valid,
	input  logic [31:0] particle_time,
	input  logic [31:0] lifetime,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] red,
	output logic [15:0] green,
	output logic [15:0] blue,
	output logic        color_written,
	output logic [16:0] fade
);

	localparam int N = pcfu_pkg::DIV_STEPS;

	pcfu_pkg::cfg_t       cfg_q;
	logic                 link_valid [N+1];
	logic                 link_ready [N+1];
	pcfu_pkg::cell_data_t link_data  [N+1];
	pcfu_pkg::cell_data_t last;
	logic                 color_blank;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pcfu_pkg::REG_COLOR_LOW:   cfg_q.color_low          <= cfg_data;
				pcfu_pkg::REG_COLOR_HIGH:  cfg_q.color_high         <= cfg_data;
				pcfu_pkg::REG_FUNC_ASSIGN: cfg_q.function_assigned  <= cfg_data[0];
				pcfu_pkg::REG_PER_PART:    cfg_q.per_particle_mode  <= cfg_data[0];
				pcfu_pkg::REG_RATE:        cfg_q.rate_of_change     <= cfg_data[23:0];
				pcfu_pkg::REG_EDGE_FADE:   cfg_q.edge_fade_fraction <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	// Color interpolation and fade classification.
	pcfu_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.color_func_value (color_func_value),
		.function_valid   (function_valid),
		.particle_time    (particle_time),
		.lifetime         (lifetime),
		.out_valid        (link_valid[0]),
		.out_data         (link_data[0]),
		.out_ready        (link_ready[0])
	);

	// Divider chain, one quotient bit per cell.
	for (genvar i = 0; i < N; i++) begin : g_cell
		pcfu_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_data   (link_data[i]),
			.in_ready  (link_ready[i]),
			.out_valid (link_valid[i+1]),
			.out_data  (link_data[i+1]),
			.out_ready (link_ready[i+1])
		);
	end

	assign link_ready[N] = !out_stall;
	assign last          = link_data[N];

	// Result fields.
	assign out_valid     = link_valid[N];
	assign red           = last.red;
	assign green         = last.green;
	assign blue          = last.blue;
	assign color_written = last.written;

	always_comb begin
		case (last.fsel)
			pcfu_pkg::FADE_ONE: fade = pcfu_pkg::ONE_Q16;
			pcfu_pkg::FADE_DIV: fade = {1'b0, last.quo};
			default:            fade = 17'd0;
		endcase
	end

	assign color_blank = red == 16'd0 && green == 16'd0 && blue == 16'd0;

	`PCFU_ASSERT(a_blank_color, clk, arst_n, out_valid && !color_written |-> color_blank)
	`PCFU_ASSERT_NEVER(a_fade_range, clk, arst_n, out_valid && fade > pcfu_pkg::ONE_Q16)
	`PCFU_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> out_valid && out_stall)

endmodule

FILE: bench/particle_color_fade_checker.sv
module particle_color_fade_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [16:0] color_func_value,
	input  logic        function_valid,
	input  logic [31:0] particle_time,
	input  logic [31:0] lifetime,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic        color_written,
	input  logic [16:0] fade,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        written;
		logic [16:0] fade;
	} particle_result_t;

	pcfu_pkg::cfg_t   shadow_cfg;
	particle_result_t expected_colors[$];

	// Restoring division: floor(num * 2^16 / den) for num below den.
	function automatic longint unsigned ramp_ratio(longint unsigned num,
			longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = num;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	// Trapezoid envelope over t/total with half of the edge fraction per ramp.
	function automatic logic [16:0] fade_envelope(logic [31:0] t, logic [31:0] total,
			logic [16:0] edge_frac);
		longint unsigned tn;
		longint unsigned eh;
		longint unsigned tot;
		longint unsigned num;
		tn = longint'(t) << 17;
		eh = longint'(edge_frac) * longint'(total);
		tot = longint'(total) << 17;
		if (total == 0)
			return '0;
		if (tn < eh)
			return 17'(ramp_ratio(tn, eh));
		if (tn + eh <= tot)
			return pcfu_pkg::ONE_Q16;
		if (edge_frac == 0 || t >= total)
			return '0;
		num = longint'(total - t) << 17;
		if (num >= eh)
			return pcfu_pkg::ONE_Q16;
		return 17'(ramp_ratio(num, eh));
	endfunction

	// Interpolate one channel between its bounds and saturate it.
	function automatic logic [15:0] lerp_channel(logic [15:0] lo_c, logic [15:0] hi_c,
			longint factor);
		longint lo;
		longint v;
		lo = lo_c;
		v = lo + (((longint'(hi_c) - lo) * factor + 32768) >>> 16);
		if (v < 0)
			return '0;
		if (v > 65535)
			return 16'hFFFF;
		return v[15:0];
	endfunction

	function automatic particle_result_t predict_particle(pcfu_pkg::cfg_t c,
			logic [16:0] fv, logic fvalid, logic [31:0] t, logic [31:0] total);
		particle_result_t res;
		longint factor;
		longint lim;
		factor = 0;
		lim = longint'(1) << 33;
		res = '0;
		if (c.function_assigned) begin
			factor = fvalid ? longint'(fv) : 0;
			res.written = 1'b1;
		end
		if (c.per_particle_mode) begin
			factor = (longint'(c.rate_of_change) * longint'(t)) >>> 16;
			if (factor > lim)
				factor = lim;
			if (factor < -lim)
				factor = -lim;
			res.written = 1'b1;
		end
		if (res.written) begin
			res.red = lerp_channel(c.color_low[47:32], c.color_high[47:32], factor);
			res.green = lerp_channel(c.color_low[31:16], c.color_high[31:16], factor);
			res.blue = lerp_channel(c.color_low[15:0], c.color_high[15:0], factor);
		end
		res.fade = fade_envelope(t, total, c.edge_fade_fraction);
		return res;
	endfunction

	// Track register writes, predict accepted particles and compare results.
	always @(posedge clk or negedge arst_n) begin
		particle_result_t want;
		particle_result_t got;
		if (!arst_n) begin
			shadow_cfg <= '0;
			fail_count <= 0;
			expected_colors.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pcfu_pkg::REG_COLOR_LOW:   shadow_cfg.color_low <= cfg_data;
					pcfu_pkg::REG_COLOR_HIGH:  shadow_cfg.color_high <= cfg_data;
					pcfu_pkg::REG_FUNC_ASSIGN: shadow_cfg.function_assigned <= cfg_data[0];
					pcfu_pkg::REG_PER_PART:    shadow_cfg.per_particle_mode <= cfg_data[0];
					pcfu_pkg::REG_RATE:        shadow_cfg.rate_of_change <= cfg_data[23:0];
					pcfu_pkg::REG_EDGE_FADE:   shadow_cfg.edge_fade_fraction <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{red, green, blue, color_written, fade};
				if (expected_colors.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_colors.pop_front();
					if (got !== want) begin
						$display("%0t: expected r=%h g=%h b=%h w=%b f=%h,",
							$realtime, want.red, want.green, want.blue, want.written,
							want.fade);
						$display("    actual r=%h g=%h b=%h w=%b f=%h",
							got.red, got.green, got.blue, got.written, got.fade);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_colors.push_back(predict_particle(shadow_cfg, color_func_value,
					function_valid, particle_time, lifetime));
			pending <= expected_colors.size();
		end
	end
endmodule

FILE: bench/particle_color_fade_unit_top_test.sv
module particle_color_fade_unit_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 200;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [16:0] color_func_value;
	logic        function_valid;
	logic [31:0] particle_time;
	logic [31:0] lifetime;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	logic        color_written;
	logic [16:0] fade;
	int          fail_count;
	int          pending;
	logic        in_taken;
	logic        cfg_taken;
	logic        hold_req;
	int          cycle_count;

	particle_color_fade_unit_top dut (.*);
	particle_color_fade_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Transaction flags seen at the rising edge, read back at the falling edge.
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		cfg_taken <= cfg_valid && cfg_ready;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stall segments, with one long hold-off once the
	// random traffic starts so that the unit fills up.
	initial begin
		int unsigned seg_len;
		int unsigned mode;
		bit held;
		held = 1'b0;
		out_stall = 1'b1;
		@(posedge arst_n);
		repeat (20) @(negedge clk);
		forever begin
			seg_len = $urandom_range(5, 60);
			mode = $urandom_range(0, 3);
			repeat (seg_len) begin
				@(negedge clk);
				if (hold_req && !held) begin
					held = 1'b1;
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering particles and wait until the unit has drained.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic set_colors(logic [47:0] lo, logic [47:0] hi, logic fa, logic pp,
			logic [23:0] rate, logic [16:0] edge_frac);
		wait_drained();
		write_reg(pcfu_pkg::REG_COLOR_LOW, lo);
		write_reg(pcfu_pkg::REG_COLOR_HIGH, hi);
		write_reg(pcfu_pkg::REG_FUNC_ASSIGN, {47'b0, fa});
		write_reg(pcfu_pkg::REG_PER_PART, {47'b0, pp});
		write_reg(pcfu_pkg::REG_RATE, {24'b0, rate});
		write_reg(pcfu_pkg::REG_EDGE_FADE, {31'b0, edge_frac});
	endtask

	// Offer one particle and hold it until the unit takes it.
	task automatic send_particle(logic [16:0] fv, logic fvl, logic [31:0] t, logic [31:0] tot,
			int unsigned gap);
		color_func_value <= fv;
		function_valid <= fvl;
		particle_time <= t;
		lifetime <= tot;
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_taken);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic random_setting();
		logic [47:0] lo;
		logic [47:0] hi;
		logic [23:0] rate;
		logic [16:0] edge_frac;
		lo = 48'({$urandom, $urandom});
		hi = 48'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: lo = '0;
			1: hi = '1;
			default: ;
		endcase
		case ($urandom_range(0, 4))
			0: rate = 24'h7FFFFF;
			1: rate = 24'h800000;
			2: rate = 24'($urandom_range(0, 255) << 8);
			3: rate = 24'(-($urandom_range(0, 65535)));
			default: rate = 24'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: edge_frac = '0;
			1: edge_frac = pcfu_pkg::ONE_Q16;
			default: edge_frac = 17'($urandom_range(0, 65536));
		endcase
		set_colors(lo, hi, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rate,
			edge_frac);
	endtask

	task automatic random_particles(int unsigned count);
		logic [16:0] fv;
		logic [31:0] t;
		logic [31:0] tot;
		int unsigned burst;
		int unsigned gap;
		burst = 0;
		gap = 0;
		for (int unsigned n = 0; n < count; n++) begin
			case ($urandom_range(0, 7))
				0: fv = pcfu_pkg::ONE_Q16;
				1: fv = '0;
				default: fv = 17'($urandom_range(0, 65536));
			endcase
			case ($urandom_range(0, 5))
				0: tot = '0;
				1: tot = '1;
				2: tot = $urandom_range(1, 1024);
				default: tot = $urandom;
			endcase
			t = ($urandom_range(0, 3) != 0) ? $urandom_range(0, tot) : $urandom;
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
			burst--;
			send_particle(fv, 1'($urandom_range(0, 1)), t, tot, (burst == 0) ? gap : 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		color_func_value = '0;
		function_valid = 1'b0;
		particle_time = '0;
		lifetime = '0;
		hold_req = 1'b0;
		cycle_count = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: no mode selected, so only the fade is formed.
		send_particle(pcfu_pkg::ONE_Q16, 1'b1, 32'h0, 32'h0, 0);
		send_particle('0, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		send_particle(17'h1FFFF, 1'b1, 32'h8000, 32'h10000, 0);

		// Function mode with full range bounds and a full edge fraction.
		set_colors('0, '1, 1'b1, 1'b0, 24'h0, pcfu_pkg::ONE_Q16);
		send_particle(pcfu_pkg::ONE_Q16, 1'b1, 32'h0, 32'h10000, 0);
		send_particle(17'h8000, 1'b1, 32'h4000, 32'h10000, 0);
		send_particle(17'h1FFFF, 1'b1, 32'h8000, 32'h10000, 0);
		send_particle(pcfu_pkg::ONE_Q16, 1'b0, 32'hC000, 32'h10000, 0);
		send_particle(17'h1, 1'b1, 32'h10000, 32'h10000, 0);
		send_particle(17'h0, 1'b1, 32'h20000, 32'h10000, 0);

		// Per-particle overrides function; extreme rates and fade ramps.
		set_colors('1, '0, 1'b1, 1'b1, 24'h7FFFFF, 17'h0);
		send_particle(pcfu_pkg::ONE_Q16, 1'b1, 32'hFFFFFFFF, 32'h0, 0);
		send_particle(pcfu_pkg::ONE_Q16, 1'b1, 32'h1, 32'h10000, 0);
		send_particle(pcfu_pkg::ONE_Q16, 1'b1, 32'h10000, 32'h10000, 0);
		set_colors(48'h0123_4567_89AB, 48'hFEDC_BA98_7654, 1'b0, 1'b1, 24'h800000, 17'h4000);
		send_particle('0, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		send_particle('0, 1'b0, 32'h1000, 32'h10000, 0);
		send_particle('0, 1'b0, 32'hF800, 32'h10000, 0);
		send_particle('0, 1'b0, 32'h1, 32'h1, 0);

		for (int p = 0; p < 10; p++) begin
			random_setting();
			if (p == 0)
				hold_req = 1'b1;
			random_particles(40);
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
